// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the bit packer RTL.
// Included by the modules that check their own invariants.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== hw/rtl/mbp_pkg.sv =====
// Package for the MSB-first bit packer: constants, opcodes and item types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mbp_pkg;

    localparam int MaxFieldBits = 64;
    localparam int DataBits     = 64;
    localparam int ByteBits     = 8;
    localparam int QueueDepth   = 4;
    localparam int QueueAw      = $clog2(QueueDepth);

    localparam logic [1:0] OpWrite    = 2'd0;
    localparam logic [1:0] OpAlign    = 2'd1;
    localparam logic [1:0] OpTrailing = 2'd2;
    localparam logic [1:0] OpFlush    = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] field_value;
        logic [6:0]  field_width;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // Bytes of one item, first byte in the top bits.
    typedef struct packed {
        logic [DataBits-1:0] data;
        logic [3:0]          nbytes;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

endpackage

`default_nettype wire

// ===== hw/rtl/msb_first_bit_packer.sv =====
// MSB-first bit packer: packs fields of 0 to 64 bits into bytes.
// Top level; depends on mbp_pkg, mbp_front, mbp_queue and mbp_back.
//
// Input channel (i_in_valid, o_in_stall, i_in_item) takes one item per cycle:
// write a field, pad to a byte with zeros, write a one bit and pad, or flush.
// The output channel (o_out_valid, i_out_stall, o_out_item) gives the bytes
// each item completes, first written bit in bit 7, with last_of_run set on
// the last byte of an item. Items that complete no byte give no output.
// The first byte of an item passes through the job queue and the output register
// after the item is accepted; the remaining bytes follow one per cycle while the
// receiver does not stall. The output side sends one byte per cycle when not
// stalled; a four-entry job queue lets short items enter back to back while
// a wide one drains.
// When the receiver stalls, the output byte holds and the queue fills; the
// input stalls only while that queue is full.
// Reset clears the pending bits, the queue and the output valid flag.
`default_nettype none

module msb_first_bit_packer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  mbp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output mbp_pkg::t_out_item o_out_item
);

    logic           accept;
    logic           full;
    logic           empty;
    logic           pop;
    mbp_pkg::t_push push;
    mbp_pkg::t_job  head;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    mbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push)
    );

    mbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    mbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_front.sv =====
// Front end of the bit packer: accepts items, merges them with the pending bits
// and hands whole bytes to the queue. Depends on mbp_pkg.
`default_nettype none

module mbp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  mbp_pkg::t_in_item     i_item,
    output mbp_pkg::t_push        o_push
);

    localparam int WordBits = mbp_pkg::DataBits + mbp_pkg::ByteBits;

    logic [7:0] r_part8;
    logic [2:0] r_count;
    logic [7:0] n_part8;
    logic [2:0] n_count;

    logic [6:0]                   width_sat;
    logic [mbp_pkg::DataBits-1:0] vshift;
    logic [WordBits-1:0]          word;
    logic [WordBits-1:0]          word_sh;
    logic [6:0]                   total;
    mbp_pkg::t_job                job;

    always_comb begin
        width_sat = (i_item.field_width > 7'(mbp_pkg::MaxFieldBits))
                  ? 7'(mbp_pkg::MaxFieldBits) : i_item.field_width;
        vshift    = i_item.field_value << (7'(mbp_pkg::DataBits) - width_sat);
        word      = {r_part8, {mbp_pkg::DataBits{1'b0}}}
                  | ({vshift, 8'b0} >> r_count);
        total     = {4'b0, r_count} + width_sat;
        word_sh   = word << {total[6:3], 3'b000};
        job       = '0;
        n_part8   = 8'b0;
        n_count   = 3'b0;
        case (i_item.opcode)
            mbp_pkg::OpWrite: begin
                job.data   = word[WordBits-1:mbp_pkg::ByteBits];
                job.nbytes = total[6:3];
                n_part8    = word_sh[WordBits-1 -: 8];
                n_count    = total[2:0];
            end
            mbp_pkg::OpTrailing: begin
                job.data   = {r_part8 | (8'h80 >> r_count), {(mbp_pkg::DataBits-8){1'b0}}};
                job.nbytes = 4'd1;
            end
            mbp_pkg::OpAlign, mbp_pkg::OpFlush: begin
                job.data   = {r_part8, {(mbp_pkg::DataBits-8){1'b0}}};
                job.nbytes = (r_count != 3'd0) ? 4'd1 : 4'd0;
            end
            default: begin
                job = '0;
            end
        endcase
        o_push.valid = i_accept && (job.nbytes != 4'd0);
        o_push.job   = job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part8 <= 8'b0;
            r_count <= 3'b0;
        end else if (i_accept) begin
            r_part8 <= n_part8;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_queue.sv =====
// Short job queue between the front and back ends of the bit packer.
// Depends on mbp_pkg and assert_macros.svh.
`default_nettype none

module mbp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mbp_pkg::t_push     i_push,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output mbp_pkg::t_job      o_head
);

    mbp_pkg::t_job                r_mem [mbp_pkg::QueueDepth];
    logic [mbp_pkg::QueueAw-1:0]  r_wr_ptr;
    logic [mbp_pkg::QueueAw-1:0]  r_rd_ptr;
    logic [mbp_pkg::QueueAw:0]    r_count;
    logic [mbp_pkg::QueueAw:0]    n_count;

    assign o_full  = (r_count == (mbp_pkg::QueueAw+1)'(mbp_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, i_push.valid && o_full)
    `ASSERT_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, i_pop && o_empty)
    `ASSERT_CHK(a_count_tracks_ptrs, i_clk, i_rst_n, (r_count == (mbp_pkg::QueueAw+1)'(mbp_pkg::QueueDepth)) || (r_count[mbp_pkg::QueueAw-1:0] == (r_wr_ptr - r_rd_ptr)))

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_back.sv =====
// Back end: drains queued jobs one byte per cycle, when not stalled, into the
// output register of the bit packer. Depends on mbp_pkg and assert_macros.svh.
`default_nettype none

module mbp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mbp_pkg::t_job      i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output mbp_pkg::t_out_item o_out_item
);

    logic                         r_out_valid;
    mbp_pkg::t_out_item           r_out_item;
    logic [mbp_pkg::DataBits-1:0] r_cur_data;
    logic [3:0]                   r_cur_left;
    logic                         slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_pop       = slot_free && (r_cur_left == 4'd0) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cur_left  <= 4'd0;
        end else if (slot_free) begin
            if (r_cur_left != 4'd0) begin
                r_out_valid            <= 1'b1;
                r_out_item.out_byte    <= r_cur_data[mbp_pkg::DataBits-1 -: 8];
                r_out_item.last_of_run <= (r_cur_left == 4'd1);
                r_cur_data             <= r_cur_data << mbp_pkg::ByteBits;
                r_cur_left             <= r_cur_left - 4'd1;
            end else if (!i_empty) begin
                r_out_valid            <= 1'b1;
                r_out_item.out_byte    <= i_head.data[mbp_pkg::DataBits-1 -: 8];
                r_out_item.last_of_run <= (i_head.nbytes == 4'd1);
                r_cur_data             <= i_head.data << mbp_pkg::ByteBits;
                r_cur_left             <= i_head.nbytes - 4'd1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

`include "assert_macros.svh"

    `ASSERT_CHK(a_left_in_range, i_clk, i_rst_n, r_cur_left <= 4'd7)
    `ASSERT_CHK(a_pop_nonempty_job, i_clk, i_rst_n, o_pop |-> (i_head.nbytes != 4'd0 && i_head.nbytes <= 4'd8))
    `ASSERT_CHK(a_mid_run_not_last, i_clk, i_rst_n, (r_cur_left != 4'd0) |-> (r_out_valid && !r_out_item.last_of_run))

endmodule

`default_nettype wire
